// ===== rtl/irb_pkg.sv =====
// Shared types, constants and the divider step of the bilinear image scaler.
`default_nettype none

package irb_pkg;

    // Fixed geometry
    localparam int SRC_IDX_W  = 8;                       // source column/row index
    localparam int SRC_SIDE_W = 9;                       // source size register
    localparam int DST_SIDE_W = 11;                      // target size register
    localparam int CRD_W      = 10;                      // request/write coordinate
    localparam int FRAC_BITS  = 8;
    localparam int Q_W        = SRC_IDX_W + FRAC_BITS;   // quotient bits kept
    localparam int NUM_W      = CRD_W + SRC_SIDE_W + FRAC_BITS;  // dividend bits
    localparam int DIV_STEPS  = NUM_W;
    localparam int PIX_W      = 32;
    localparam int CHAN_N     = 4;
    localparam int CH_CNT_W   = 3;
    localparam int ADDR_W     = 2 * SRC_IDX_W;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SRC_SIDE_W-1:0] MAX_SRC_SIDE = 9'd256;
    localparam logic [DST_SIDE_W-1:0] MAX_DST_SIDE = 11'd1024;
    localparam logic [CH_CNT_W-1:0]   MAX_CHANNELS = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_SRC_W  = 3'd0;
    localparam logic [2:0] REG_SRC_H  = 3'd1;
    localparam logic [2:0] REG_DST_W  = 3'd2;
    localparam logic [2:0] REG_DST_H  = 3'd3;
    localparam logic [2:0] REG_CH_CNT = 3'd4;

    // Operation codes
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [SRC_SIDE_W-1:0] sw;
        logic [SRC_SIDE_W-1:0] sh;
        logic [DST_SIDE_W-1:0] tw;
        logic [DST_SIDE_W-1:0] th;
        logic [CH_CNT_W-1:0]   nc;
    } cfg_t;

    // One classified operation between front and back
    typedef struct packed {
        logic                 is_req;
        logic [SRC_IDX_W-1:0] x0;
        logic [SRC_IDX_W-1:0] x1;
        logic [SRC_IDX_W-1:0] y0;
        logic [SRC_IDX_W-1:0] y1;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic [PIX_W-1:0]     data;
    } entry_t;

    // One restoring-division step: returns {quotient bit, new remainder}
    function automatic logic [DST_SIDE_W:0] div_step(
        input logic [DST_SIDE_W-1:0] rem,
        input logic                  nbit,
        input logic [DST_SIDE_W-1:0] dvs
    );
        logic [DST_SIDE_W:0] t;
        logic [DST_SIDE_W:0] d;
        t = {rem, nbit};
        d = {1'b0, dvs};
        if (t >= d)
            div_step = {1'b1, DST_SIDE_W'(t - d)};
        else
            div_step = {1'b0, t[DST_SIDE_W-1:0]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/irb_front.sv =====
// Front part: maps coordinates through a pipelined divider and classifies items.
`default_nettype none

module irb_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire irb_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_op,
    input  wire logic [irb_pkg::CRD_W-1:0]     in_x,
    input  wire logic [irb_pkg::CRD_W-1:0]     in_y,
    input  wire logic [irb_pkg::PIX_W-1:0]     in_data,
    output logic                               push,
    output irb_pkg::entry_t                    push_entry,
    input  wire logic                          q_full
);

    localparam int NS = irb_pkg::DIV_STEPS;
    localparam int RW = irb_pkg::DST_SIDE_W;
    localparam int FB = irb_pkg::FRAC_BITS;
    localparam int IW = irb_pkg::SRC_IDX_W;
    localparam int NW = irb_pkg::NUM_W;
    localparam int PW = irb_pkg::CRD_W + irb_pkg::SRC_SIDE_W;

    // Stage registers, stage 0 after the multiply, stage NS holds the quotient
    logic                          v_reg    [0:NS];
    logic                          op_reg   [0:NS];
    logic [irb_pkg::CRD_W-1:0]     x_reg    [0:NS];
    logic [irb_pkg::CRD_W-1:0]     y_reg    [0:NS];
    logic [irb_pkg::PIX_W-1:0]     data_reg [0:NS];
    logic                          ovx_reg  [0:NS];
    logic                          ovy_reg  [0:NS];
    logic [RW-1:0]                 remx_reg [0:NS];
    logic [RW-1:0]                 remy_reg [0:NS];
    logic [NW-1:0]                 nlx_reg  [0:NS];
    logic [NW-1:0]                 nly_reg  [0:NS];
    logic [irb_pkg::Q_W-1:0]       qx_reg   [0:NS];
    logic [irb_pkg::Q_W-1:0]       qy_reg   [0:NS];

    logic [RW:0]                   stx_next [0:NS-1];
    logic [RW:0]                   sty_next [0:NS-1];

    logic [PW-1:0]                 prodx;
    logic [PW-1:0]                 prody;
    logic                          stall;
    logic                          adv;

    // Pipeline moves as a whole unless the last stage is blocked by the queue
    assign stall    = v_reg[NS] && q_full;
    assign adv      = !stall;
    assign in_ready = adv;

    // Position numerators d * src
    assign prodx = PW'(in_x) * PW'(cfg.sw);
    assign prody = PW'(in_y) * PW'(cfg.sh);

    // One divider step per stage
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            stx_next[k] = irb_pkg::div_step(remx_reg[k], nlx_reg[k][NW-1], cfg.tw);
            sty_next[k] = irb_pkg::div_step(remy_reg[k], nly_reg[k][NW-1], cfg.th);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++)
                v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < NS; k++)
                v_reg[k+1] <= v_reg[k];
        end
    end

    // Payload; the whole dividend is shifted through so the low quotient bits
    // stay exact even when the coordinate lies outside the target
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg[0]   <= in_op;
            x_reg[0]    <= in_x;
            y_reg[0]    <= in_y;
            data_reg[0] <= in_data;
            ovx_reg[0]  <= {1'b0, in_x} >= cfg.tw;
            ovy_reg[0]  <= {1'b0, in_y} >= cfg.th;
            remx_reg[0] <= '0;
            remy_reg[0] <= '0;
            nlx_reg[0]  <= {prodx, {FB{1'b0}}};
            nly_reg[0]  <= {prody, {FB{1'b0}}};
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            for (int k = 0; k < NS; k++)
            begin
                op_reg[k+1]   <= op_reg[k];
                x_reg[k+1]    <= x_reg[k];
                y_reg[k+1]    <= y_reg[k];
                data_reg[k+1] <= data_reg[k];
                ovx_reg[k+1]  <= ovx_reg[k];
                ovy_reg[k+1]  <= ovy_reg[k];
                remx_reg[k+1] <= stx_next[k][RW-1:0];
                remy_reg[k+1] <= sty_next[k][RW-1:0];
                nlx_reg[k+1]  <= {nlx_reg[k][NW-2:0], 1'b0};
                nly_reg[k+1]  <= {nly_reg[k][NW-2:0], 1'b0};
                qx_reg[k+1]   <= {qx_reg[k][irb_pkg::Q_W-2:0], stx_next[k][RW]};
                qy_reg[k+1]   <= {qy_reg[k][irb_pkg::Q_W-2:0], sty_next[k][RW]};
            end
        end
    end

    // Clamp neighbours and classify the finished item
    always_comb
    begin
        logic [IW-1:0]                 lastx;
        logic [IW-1:0]                 lasty;
        logic [IW-1:0]                 ix;
        logic [IW-1:0]                 iy;
        logic [IW-1:0]                 lx;
        logic [IW-1:0]                 ly;
        logic                          in_src;
        lastx  = IW'(cfg.sw - 9'd1);
        lasty  = IW'(cfg.sh - 9'd1);
        ix     = qx_reg[NS][irb_pkg::Q_W-1:FB];
        iy     = qy_reg[NS][irb_pkg::Q_W-1:FB];
        lx     = (ovx_reg[NS] || (ix > lastx)) ? lastx : ix;
        ly     = (ovy_reg[NS] || (iy > lasty)) ? lasty : iy;
        in_src = ({1'b0, x_reg[NS]} < {2'b00, cfg.sw}) &&
                 ({1'b0, y_reg[NS]} < {2'b00, cfg.sh});

        push_entry.is_req = op_reg[NS];
        push_entry.data   = data_reg[NS];
        push_entry.fx     = qx_reg[NS][FB-1:0];
        push_entry.fy     = qy_reg[NS][FB-1:0];
        if (op_reg[NS] == irb_pkg::OP_REQUEST)
        begin
            push_entry.x0 = lx;
            push_entry.y0 = ly;
            push_entry.x1 = ({1'b0, lx} + 9'd1 < cfg.sw) ? lx + 8'd1 : lx;
            push_entry.y1 = ({1'b0, ly} + 9'd1 < cfg.sh) ? ly + 8'd1 : ly;
        end
        else
        begin
            push_entry.x0 = x_reg[NS][IW-1:0];
            push_entry.y0 = y_reg[NS][IW-1:0];
            push_entry.x1 = x_reg[NS][IW-1:0];
            push_entry.y1 = y_reg[NS][IW-1:0];
        end
        // writes outside the source image are dropped here
        push = v_reg[NS] && !q_full && (op_reg[NS] == irb_pkg::OP_REQUEST || in_src);
    end

endmodule

`default_nettype wire

// ===== rtl/irb_queue.sv =====
// Short queue of classified operations between front and back.
`default_nettype none

module irb_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire irb_pkg::entry_t push_entry,
    output logic                 full,
    input  wire logic            pop,
    output irb_pkg::entry_t      head,
    output logic                 empty
);

    localparam int D  = irb_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(D);

    irb_pkg::entry_t slot_reg [0:D-1];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign full  = count_reg == (PW+1)'(D);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== rtl/irb_back.sv =====
// Back part: frame store, neighbour read sequencer and bilinear blend.
`default_nettype none

module irb_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [irb_pkg::CH_CNT_W-1:0]   nc,
    input  wire logic                           q_empty,
    input  wire irb_pkg::entry_t                head,
    output logic                                pop,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [irb_pkg::PIX_W-1:0]           m_data
);

    localparam int FB = irb_pkg::FRAC_BITS;
    localparam int NC = irb_pkg::CHAN_N;
    localparam int UW = 2 * FB;          // one horizontal lerp, scaled by S
    localparam int VW = 3 * FB + 1;      // vertical lerp plus rounding

    // Read phases of one request
    localparam logic [1:0] PH_TL = 2'd0;
    localparam logic [1:0] PH_TR = 2'd1;
    localparam logic [1:0] PH_BL = 2'd2;
    localparam logic [1:0] PH_BR = 2'd3;

    logic [irb_pkg::PIX_W-1:0] mem [0:(1 << irb_pkg::ADDR_W)-1];

    logic                      busy_reg;
    logic [1:0]                ph_reg;
    irb_pkg::entry_t           cur_reg;
    logic                      rd_v_reg;
    logic [1:0]                rd_ph_reg;
    logic [FB-1:0]             rd_fx_reg;
    logic [FB-1:0]             rd_fy_reg;
    logic [irb_pkg::PIX_W-1:0] rd_data_reg;
    logic [irb_pkg::PIX_W-1:0] tl_reg;
    logic [irb_pkg::PIX_W-1:0] tr_reg;
    logic [irb_pkg::PIX_W-1:0] bl_reg;
    logic                      a_v_reg;
    logic [FB-1:0]             a_fy_reg;
    logic [UW-1:0]             up_reg [0:NC-1];
    logic [UW-1:0]             lo_reg [0:NC-1];
    logic                      out_v_reg;
    logic [irb_pkg::PIX_W-1:0] out_data_reg;

    irb_pkg::entry_t           act;
    logic                      have;
    logic                      adv;
    logic                      issue;
    logic                      mem_we;
    logic                      mem_re;
    logic                      last;
    logic [irb_pkg::ADDR_W-1:0] addr;
    logic [UW-1:0]             up_next [0:NC-1];
    logic [UW-1:0]             lo_next [0:NC-1];
    logic [irb_pkg::PIX_W-1:0] out_next;

    // Whole back pipeline steps when the output register can move
    assign adv     = !out_v_reg || m_ready;
    assign have    = busy_reg || !q_empty;
    assign act     = busy_reg ? cur_reg : head;
    assign issue   = adv && have;
    assign mem_we  = issue && !act.is_req;
    assign mem_re  = issue && act.is_req;
    assign last    = act.is_req && (ph_reg == PH_BR);
    assign pop     = adv && !busy_reg && !q_empty;
    assign m_valid = out_v_reg;
    assign m_data  = out_data_reg;

    // Frame store address per phase
    always_comb
    begin
        unique case (ph_reg)
            PH_TL: addr = {act.y0, act.x0};
            PH_TR: addr = {act.y0, act.x1};
            PH_BL: addr = {act.y1, act.x0};
            PH_BR: addr = {act.y1, act.x1};
            default: addr = {act.y0, act.x0};
        endcase
    end

    // Sequencer: one frame store access per write, four reads per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            ph_reg    <= PH_TL;
            rd_v_reg  <= 1'b0;
            a_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (have && act.is_req && !last)
            begin
                busy_reg <= 1'b1;
                ph_reg   <= ph_reg + 2'd1;
            end
            else
            begin
                busy_reg <= 1'b0;
                ph_reg   <= PH_TL;
            end
            rd_v_reg  <= mem_re;
            a_v_reg   <= rd_v_reg && (rd_ph_reg == PH_BR);
            out_v_reg <= a_v_reg;
        end
    end

    // Held operation while its reads are issued
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
    end

    // Single-port frame store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr] <= act.data;
        if (mem_re)
            rd_data_reg <= mem[addr];
    end

    // Read tags and neighbour capture
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_ph_reg <= ph_reg;
            rd_fx_reg <= act.fx;
            rd_fy_reg <= act.fy;
            if (rd_v_reg)
            begin
                unique case (rd_ph_reg)
                    PH_TL: tl_reg <= rd_data_reg;
                    PH_TR: tr_reg <= rd_data_reg;
                    PH_BL: bl_reg <= rd_data_reg;
                    PH_BR: ;
                    default: ;
                endcase
            end
        end
    end

    // Horizontal lerps, last neighbour straight from the read register
    always_comb
    begin
        logic [FB:0] wl;
        wl = (FB+1)'(1 << FB) - {1'b0, rd_fx_reg};
        for (int c = 0; c < NC; c++)
        begin
            up_next[c] = UW'((UW+1)'(tl_reg[8*c +: 8]) * (UW+1)'(wl) +
                             (UW+1)'(tr_reg[8*c +: 8]) * (UW+1)'(rd_fx_reg));
            lo_next[c] = UW'((UW+1)'(bl_reg[8*c +: 8]) * (UW+1)'(wl) +
                             (UW+1)'(rd_data_reg[8*c +: 8]) * (UW+1)'(rd_fx_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_fy_reg <= rd_fy_reg;
            for (int c = 0; c < NC; c++)
            begin
                up_reg[c] <= up_next[c];
                lo_reg[c] <= lo_next[c];
            end
        end
    end

    // Vertical lerp, round half up, unused channels forced to zero
    always_comb
    begin
        logic [FB:0]   wt;
        logic [VW-1:0] v;
        wt = (FB+1)'(1 << FB) - {1'b0, a_fy_reg};
        out_next = '0;
        for (int c = 0; c < NC; c++)
        begin
            v = VW'(up_reg[c]) * VW'(wt) + VW'(lo_reg[c]) * VW'(a_fy_reg) +
                VW'(1 << (2*FB - 1));
            if (irb_pkg::CH_CNT_W'(c) < nc)
                out_next[8*c +: 8] = v[2*FB +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= out_next;
    end

    a_busy_is_request: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cur_reg.is_req && ph_reg != PH_TL))
        else $error("sequencer busy without a request past its first read");

    a_last_read_blends: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_v_reg && rd_ph_reg == PH_BR && adv) |=> a_v_reg)
        else $error("last neighbour read did not start a blend");

    a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!busy_reg && adv))
        else $error("queue popped while a request is in progress");

endmodule

`default_nettype wire

// ===== rtl/image_resize_bilinear.sv =====
// Top level of the bilinear image scaler: registers, front, queue and back.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata coords+channels, s_tuser operation
//  m_*      out  m_tvalid/m_tready  m_tdata interpolated channels
//  cfg_*    in   cfg_we             cfg_index, cfg_wdata
//
// A write is one frame store access, a request four reads (one per neighbour on
// the single-ported frame store); input is taken every cycle unless the last
// front stage holds an item and the queue is full. A request passes the multiply
// register and 27 divider stages, queue, 4 reads, 2 blend stages. Reset clears
// control only; the frame store is undefined until written. A stalled m_tready
// holds the back part while the front keeps filling the queue.
`default_nettype none

module image_resize_bilinear (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // coord_x, coord_y, in_chan0..in_chan3, zero pad
    input  wire logic        s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_chan0..out_chan3
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [10:0] cfg_wdata
);

    logic [8:0]      src_w_reg;
    logic [8:0]      src_h_reg;
    logic [10:0]     dst_w_reg;
    logic [10:0]     dst_h_reg;
    logic [2:0]      ch_cnt_reg;
    irb_pkg::cfg_t   cfg;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    irb_pkg::entry_t push_entry;
    irb_pkg::entry_t head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg  <= 9'd256;
            src_h_reg  <= 9'd256;
            dst_w_reg  <= 11'd256;
            dst_h_reg  <= 11'd256;
            ch_cnt_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                irb_pkg::REG_SRC_W:  src_w_reg  <= cfg_wdata[8:0];
                irb_pkg::REG_SRC_H:  src_h_reg  <= cfg_wdata[8:0];
                irb_pkg::REG_DST_W:  dst_w_reg  <= cfg_wdata;
                irb_pkg::REG_DST_H:  dst_h_reg  <= cfg_wdata;
                irb_pkg::REG_CH_CNT: ch_cnt_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // Clamp registers to their legal ranges
    always_comb
    begin
        cfg.sw = (src_w_reg == '0) ? 9'd1 :
                 (src_w_reg > irb_pkg::MAX_SRC_SIDE) ? irb_pkg::MAX_SRC_SIDE : src_w_reg;
        cfg.sh = (src_h_reg == '0) ? 9'd1 :
                 (src_h_reg > irb_pkg::MAX_SRC_SIDE) ? irb_pkg::MAX_SRC_SIDE : src_h_reg;
        cfg.tw = (dst_w_reg == '0) ? 11'd1 :
                 (dst_w_reg > irb_pkg::MAX_DST_SIDE) ? irb_pkg::MAX_DST_SIDE : dst_w_reg;
        cfg.th = (dst_h_reg == '0) ? 11'd1 :
                 (dst_h_reg > irb_pkg::MAX_DST_SIDE) ? irb_pkg::MAX_DST_SIDE : dst_h_reg;
        cfg.nc = (ch_cnt_reg == '0) ? 3'd1 :
                 (ch_cnt_reg > irb_pkg::MAX_CHANNELS) ? irb_pkg::MAX_CHANNELS : ch_cnt_reg;
    end

    irb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_x       (s_tdata[9:0]),
        .in_y       (s_tdata[19:10]),
        .in_data    (s_tdata[51:20]),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    irb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    irb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .nc      (cfg.nc),
        .q_empty (q_empty),
        .head    (head),
        .pop     (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== test/image_resize_bilinear_test.sv =====
// Self-checking testbench for the bilinear image scaler: frame store writes and pixel requests.
`default_nettype none

module image_resize_bilinear_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [3:0][7:0] pixel_t;

    // One row of the directed table; a typed result is used when known is set
    typedef struct {
        logic   op;
        int     x;
        int     y;
        pixel_t pix;
        bit     known;
        pixel_t known_pix;
    } vector_t;

    // Raw register settings for one phase
    typedef struct {
        int sw;
        int sh;
        int tw;
        int th;
        int nc;
    } setting_t;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 90;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // coord_x, coord_y, in_chan0..in_chan3, zero pad
    logic        s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // out_chan0..out_chan3
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [10:0] cfg_wdata;

    // Shadow of the block state
    pixel_t store_pix [65536];
    bit     store_valid [65536];
    int     reg_sw, reg_sh, reg_tw, reg_th, reg_nc;

    pixel_t pixel_queue [$];
    int     mismatches;
    bit     failed;
    bit     no_idle;
    int     cycles;

    image_resize_bilinear u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run-length guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int clamp_to(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int eff_sw();
        return clamp_to(reg_sw, irb_pkg::MAX_SRC_SIDE);
    endfunction

    function automatic int eff_sh();
        return clamp_to(reg_sh, irb_pkg::MAX_SRC_SIDE);
    endfunction

    function automatic int eff_tw();
        return clamp_to(reg_tw, irb_pkg::MAX_DST_SIDE);
    endfunction

    function automatic int eff_th();
        return clamp_to(reg_th, irb_pkg::MAX_DST_SIDE);
    endfunction

    // Destination coordinate to source neighbour pair and fraction
    function automatic void map_coord(input int d, input int src, input int dst,
                                      output int lo, output int hi, output int fr);
        int pos;
        pos = ((d * src) << irb_pkg::FRAC_BITS) / dst;
        lo = pos >> irb_pkg::FRAC_BITS;
        fr = pos & ((1 << irb_pkg::FRAC_BITS) - 1);
        if (lo > src - 1)
            lo = src - 1;
        hi = (lo + 1 < src) ? lo + 1 : src - 1;
    endfunction

    // Address of a neighbour not yet written, or -1 when all four are known
    function automatic int unwritten_neighbour(input int x, input int y);
        int xl, xr, yt, yb, fx, fy;
        int addrs [4];
        map_coord(x, eff_sw(), eff_tw(), xl, xr, fx);
        map_coord(y, eff_sh(), eff_th(), yt, yb, fy);
        addrs = '{yt * 256 + xl, yt * 256 + xr, yb * 256 + xl, yb * 256 + xr};
        foreach (addrs[i])
            if (!store_valid[addrs[i]])
                return addrs[i];
        return -1;
    endfunction

    // Bilinear blend of the four neighbours, channel by channel
    function automatic pixel_t blend_pixel(input int x, input int y);
        int xl, xr, yt, yb, fx, fy, nc;
        longint upper, lower, v;
        pixel_t tl, tr, bl, br, res;
        map_coord(x, eff_sw(), eff_tw(), xl, xr, fx);
        map_coord(y, eff_sh(), eff_th(), yt, yb, fy);
        tl = store_pix[yt * 256 + xl];
        tr = store_pix[yt * 256 + xr];
        bl = store_pix[yb * 256 + xl];
        br = store_pix[yb * 256 + xr];
        nc = clamp_to(reg_nc, irb_pkg::MAX_CHANNELS);
        res = '0;
        for (int c = 0; c < irb_pkg::CHAN_N; c++)
        begin
            if (c < nc)
            begin
                upper = longint'(tl[c]) * (256 - fx) + longint'(tr[c]) * fx;
                lower = longint'(bl[c]) * (256 - fx) + longint'(br[c]) * fx;
                v = upper * (256 - fy) + lower * fy;
                res[c] = 8'((v + 32768) >> 16);
            end
        end
        return res;
    endfunction

    // One input transfer; valid stays high into the next item when there is no gap
    task automatic send_item(input logic op, input int x, input int y, input pixel_t pix,
                             input bit known, input pixel_t known_pix);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'd0, pix, 10'(y), 10'(x)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == irb_pkg::OP_WRITE)
        begin
            if (x < eff_sw() && y < eff_sh())
            begin
                store_pix[y * 256 + x] = pix;
                store_valid[y * 256 + x] = 1'b1;
            end
        end
        else
            pixel_queue.push_back(known ? known_pix : blend_pixel(x, y));
    endtask

    // Let the block drain before touching the registers
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pixel_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= 11'(val);
        case (idx)
            irb_pkg::REG_SRC_W:  reg_sw = val & 'h1FF;
            irb_pkg::REG_SRC_H:  reg_sh = val & 'h1FF;
            irb_pkg::REG_DST_W:  reg_tw = val & 'h7FF;
            irb_pkg::REG_DST_H:  reg_th = val & 'h7FF;
            irb_pkg::REG_CH_CNT: reg_nc = val & 'h7;
            default: ;
        endcase
    endtask

    // Result side: random stalls, compare with the oldest expectation
    initial
    begin
        int stall;
        pixel_t want;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            if (stall > 0 || !m_tready)
            begin
                @(negedge clk);
                m_tready <= 1'b1;
            end
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if (pixel_queue.size() == 0)
            begin
                failed = 1'b1;
                if (mismatches < 10)
                    $display("unexpected result transfer %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = pixel_queue.pop_front();
                for (int c = 0; c < irb_pkg::CHAN_N; c++)
                begin
                    if (m_tdata[8 * c +: 8] !== want[c])
                    begin
                        failed = 1'b1;
                        if (mismatches < 10)
                            $display("out_chan%0d: expected %h, got %h", c, want[c],
                                     m_tdata[8 * c +: 8]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        vector_t  vectors [$];
        setting_t phases [$];
        int       count, x, y, miss, sw, sh;
        pixel_t   pix;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = irb_pkg::OP_WRITE;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = irb_pkg::REG_SRC_W;
        cfg_wdata = '0;
        mismatches = 0;
        failed = 1'b0;
        no_idle = 1'b0;
        cycles = 0;
        reg_sw = 256;
        reg_sh = 256;
        reg_tw = 256;
        reg_th = 256;
        reg_nc = 4;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows at reset sizes: equal sizes pass pixels through unchanged
        vectors = '{
            '{irb_pkg::OP_WRITE, 255, 255, 32'hFFFFFFFF, 0, 0},
            '{irb_pkg::OP_WRITE, 254, 255, 32'h00000000, 0, 0},
            '{irb_pkg::OP_WRITE, 255, 254, 32'h12345678, 0, 0},
            '{irb_pkg::OP_WRITE, 254, 254, 32'hA5A5A5A5, 0, 0},
            '{irb_pkg::OP_WRITE, 0, 0, 32'h04030201, 0, 0},
            '{irb_pkg::OP_WRITE, 1, 0, 32'hFFFFFFFF, 0, 0},
            '{irb_pkg::OP_WRITE, 0, 1, 32'h00000000, 0, 0},
            '{irb_pkg::OP_WRITE, 1, 1, 32'h80808080, 0, 0},
            '{irb_pkg::OP_WRITE, 2, 0, 32'h11223344, 0, 0},
            '{irb_pkg::OP_WRITE, 2, 1, 32'h55667788, 0, 0},
            '{irb_pkg::OP_WRITE, 1023, 7, 32'hDEADBEEF, 0, 0},
            '{irb_pkg::OP_WRITE, 7, 1023, 32'hDEADBEEF, 0, 0},
            '{irb_pkg::OP_REQUEST, 255, 255, 0, 1, 32'hFFFFFFFF},
            '{irb_pkg::OP_REQUEST, 1023, 1023, 0, 1, 32'hFFFFFFFF},
            '{irb_pkg::OP_REQUEST, 254, 254, 0, 1, 32'hA5A5A5A5},
            '{irb_pkg::OP_REQUEST, 255, 254, 0, 1, 32'h12345678},
            '{irb_pkg::OP_REQUEST, 1023, 254, 0, 1, 32'h12345678},
            '{irb_pkg::OP_REQUEST, 0, 0, 0, 1, 32'h04030201},
            '{irb_pkg::OP_REQUEST, 1, 0, 0, 0, 0},
            '{irb_pkg::OP_REQUEST, 0, 0, 0, 1, 32'h04030201}
        };
        foreach (vectors[i])
            send_item(vectors[i].op, vectors[i].x, vectors[i].y, vectors[i].pix,
                      vectors[i].known, vectors[i].known_pix);
        settle();

        // Register settings, out-of-range values among them
        phases = '{
            '{8, 6, 20, 15, 3},
            '{1, 1, 1, 1, 1},
            '{0, 0, 0, 0, 0},
            '{511, 3, 2047, 5, 7},
            '{5, 256, 3, 700, 2},
            '{16, 16, 7, 9, 4},
            '{3, 4, 1024, 1024, 1},
            '{12, 10, 12, 10, 4},
            '{256, 2, 256, 2, 2},
            '{256, 256, 1024, 1024, 4}
        };
        foreach (phases[p])
        begin
            write_reg(irb_pkg::REG_SRC_W, phases[p].sw);
            write_reg(irb_pkg::REG_SRC_H, phases[p].sh);
            write_reg(irb_pkg::REG_DST_W, phases[p].tw);
            write_reg(irb_pkg::REG_DST_H, phases[p].th);
            write_reg(irb_pkg::REG_CH_CNT, phases[p].nc);
            // index beyond the register list is dropped
            write_reg(irb_pkg::REG_CH_CNT + 3'($urandom_range(1, 3)),
                      $urandom_range(0, 2047));
            @(negedge clk);
            cfg_we <= 1'b0;
            no_idle = (p % 4 == 3);

            sw = eff_sw();
            sh = eff_sh();
            // Small images are filled completely up front
            if (sw * sh <= 64)
                for (int yy = 0; yy < sh; yy++)
                    for (int xx = 0; xx < sw; xx++)
                        send_item(irb_pkg::OP_WRITE, xx, yy, $urandom, 0, 0);

            count = 0;
            while (count < PHASE_ITEMS)
            begin
                pix = $urandom;
                if ($urandom_range(0, 99) < 25)
                begin
                    if ($urandom_range(0, 99) < 85)
                    begin
                        x = $urandom_range(0, sw - 1);
                        y = $urandom_range(0, sh - 1);
                        count++;
                    end
                    else
                    begin
                        x = $urandom_range(0, 1023);
                        y = $urandom_range(0, 1023);
                    end
                    send_item(irb_pkg::OP_WRITE, x, y, pix, 0, 0);
                end
                else
                begin
                    if ($urandom_range(0, 99) < 85)
                    begin
                        x = $urandom_range(0, eff_tw() - 1);
                        y = $urandom_range(0, eff_th() - 1);
                    end
                    else
                    begin
                        x = $urandom_range(0, 1023);
                        y = $urandom_range(0, 1023);
                    end
                    // Fill a missing neighbour first so no unwritten entry is read
                    miss = unwritten_neighbour(x, y);
                    if (miss < 0)
                        send_item(irb_pkg::OP_REQUEST, x, y, 0, 0, 0);
                    else
                        send_item(irb_pkg::OP_WRITE, miss % 256, miss / 256, pix, 0, 0);
                    count++;
                end
            end
            settle();
        end

        if (!failed)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/irb_pkg.sv
rtl/irb_front.sv
rtl/irb_queue.sv
rtl/irb_back.sv
rtl/image_resize_bilinear.sv
test/image_resize_bilinear_test.sv
